// File: hw/rtl/fppid_pkg.sv
// Shared types, constants and helper functions of the fixed-point PID controller.
`default_nettype none

package fppid_pkg;

    // Fixed-point format and field widths.
    localparam int FRAC_BITS = 10;
    localparam int DATA_W    = 16;
    localparam int TIME_W    = 32;
    localparam int PER_W     = 10;
    localparam int ACC_W     = 48;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int ERR_W     = DATA_W + 1;

    // Effective gain widths: scaled by 32, negated, and kd times up to 1000.
    localparam int KP_W = 22;
    localparam int KI_W = 22;
    localparam int KD_W = 32;

    // Working width of the output datapath.
    localparam int CALC_W = 52;

    // Gain derivation constants.
    localparam int GAIN_SHIFT  = 5;     // gains are scaled by 32
    localparam int PERIOD_BASE = 1000;  // milliseconds per second
    localparam int D_SHIFT     = 2;     // derivative term is divided by 4
    localparam int INV_W       = 10;

    // Shared iterative divider.
    localparam int DIV_NUM_W = DATA_W + GAIN_SHIFT;
    localparam int DIV_DEN_W = INV_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Stream word widths.
    localparam int S_FIELDS_W = 2 * TIME_W + 2 * DATA_W + 1;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = DATA_W;
    localparam int M_TUSER_W  = 2;

    // Item commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_AUTO   = 2'd1,
        CMD_MANUAL = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_RAW_GAINS = 3'd3,
        CFG_PERIOD    = 3'd4,
        CFG_OUT_MIN   = 3'd5,
        CFG_OUT_MAX   = 3'd6,
        CFG_REVERSE   = 3'd7
    } t_cfg_idx;

    // Effective gains in use by the datapath.
    typedef struct packed {
        logic signed [KP_W-1:0] kp;
        logic signed [KI_W-1:0] ki;
        logic signed [KD_W-1:0] kd;
    } t_gains;

    // Gain derivation status toward the top level.
    typedef struct packed {
        logic   busy;
        t_gains gains;
    } t_gain_status;

    // One input item.
    typedef struct packed {
        t_cmd                     cmd;
        logic [TIME_W-1:0]        now;
        logic [DATA_W-1:0]        meas;
        logic [DATA_W-1:0]        sp;
        logic signed [DATA_W-1:0] ff;
        logic                     p_on_error;
        logic signed [DATA_W-1:0] manual;
    } t_item;

    // Controller state carried from item to item.
    typedef struct packed {
        logic signed [ACC_W-1:0]  acc;
        logic [DATA_W-1:0]        prev;
        logic [TIME_W-1:0]        last;
        logic                     auto_on;
        logic signed [DATA_W-1:0] held;
    } t_state;

    // Active output limits.
    typedef struct packed {
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
    } t_limits;

    // Saturate a value to [lo, hi].
    function automatic logic signed [CALC_W-1:0] f_clamp(
        input logic signed [CALC_W-1:0] i_v,
        input logic signed [CALC_W-1:0] i_lo,
        input logic signed [CALC_W-1:0] i_hi
    );
        logic signed [CALC_W-1:0] v_r;
        if (i_v > i_hi) begin
            v_r = i_hi;
        end else if (i_v < i_lo) begin
            v_r = i_lo;
        end else begin
            v_r = i_v;
        end
        return v_r;
    endfunction

    // Bring a value in output units into the fixed-point format.
    function automatic logic signed [CALC_W-1:0] f_scale(
        input logic signed [DATA_W-1:0] i_v
    );
        logic signed [CALC_W-1:0] v_w;
        v_w = CALC_W'(i_v);
        return v_w <<< FRAC_BITS;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fixed_point_pid_feedforward.sv
// Top level of the fixed-point PID controller with feedforward.
//
//  channel   direction  handshake            payload
//  s stream  in         i_s_tvalid/o_s_tready i_s_tdata, i_s_tuser (command)
//  m stream  out        o_m_tvalid/i_m_tready o_m_tdata (drive), o_m_tuser
//  cfg       in         i_cfg_wr_en           i_cfg_idx, i_cfg_wdata
//
// One word per cycle sustained unless the output stalls or gains are derived; a
// word passes the input register, the single-pass datapath with three multipliers
// and the result register. A write to a gain, raw_gains, sample_period or
// reverse_direction register starts the gain sequencer, whose shared 21-step
// divider holds the input during the write cycle and until the gains are set.
// Synchronous active-low reset initialises all control state; no clearing pass is needed.
// The result register lets a new word enter while the previous result waits.
`default_nettype none

module fixed_point_pid_feedforward (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Configuration write port.
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [fppid_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [fppid_pkg::DATA_W-1:0]         i_cfg_wdata,
    // Input stream.
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    // tdata: now_ms[31:0], measured_value[47:32], setpoint[63:48],
    //        feed_forward[79:64], p_on_error[80], manual_output[96:81], zeros above
    input  wire logic [fppid_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // tuser: command[1:0]
    input  wire logic [fppid_pkg::CMD_W-1:0]          i_s_tuser,
    // Output stream.
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    // tdata: drive_output[15:0]
    output logic [fppid_pkg::M_TDATA_W-1:0]           o_m_tdata,
    // tuser: computed[0], auto_active[1]
    output logic [fppid_pkg::M_TUSER_W-1:0]           o_m_tuser
);

    // Configuration registers.
    logic signed [fppid_pkg::DATA_W-1:0] r_gain_p;
    logic signed [fppid_pkg::DATA_W-1:0] r_gain_i;
    logic signed [fppid_pkg::DATA_W-1:0] r_gain_d;
    logic                                r_raw;
    logic [fppid_pkg::PER_W-1:0]         r_period;
    logic signed [fppid_pkg::DATA_W-1:0] r_out_min;
    logic signed [fppid_pkg::DATA_W-1:0] r_out_max;
    logic                                r_reverse;
    fppid_pkg::t_limits                  r_lim;

    // Controller state and pipeline registers.
    fppid_pkg::t_state                   r_st;
    logic                                r_in_valid;
    logic [fppid_pkg::S_TDATA_W-1:0]     r_in_data;
    logic [fppid_pkg::CMD_W-1:0]         r_in_user;
    logic                                r_out_valid;
    logic [fppid_pkg::M_TDATA_W-1:0]     r_out_data;
    logic [fppid_pkg::M_TUSER_W-1:0]     r_out_user;

    logic                                w_gain_start;
    logic                                w_lim_wr;
    fppid_pkg::t_gain_status             w_gstat;
    fppid_pkg::t_item                    w_item;
    fppid_pkg::t_state                   w_next;
    logic                                w_computed;
    logic                                w_adv;
    logic                                w_accept;
    logic signed [fppid_pkg::DATA_W-1:0] w_new_min;
    logic signed [fppid_pkg::DATA_W-1:0] w_new_max;
    logic                                w_lim_ok;
    logic signed [fppid_pkg::CALC_W-1:0] w_acc_clamped;
    logic signed [fppid_pkg::DATA_W-1:0] w_held_clamped;

    // Register index decode.
    always_comb begin
        w_gain_start = 1'b0;
        w_lim_wr     = 1'b0;
        unique case (fppid_pkg::t_cfg_idx'(i_cfg_idx)) inside
            fppid_pkg::CFG_GAIN_P, fppid_pkg::CFG_GAIN_I, fppid_pkg::CFG_GAIN_D,
            fppid_pkg::CFG_RAW_GAINS, fppid_pkg::CFG_PERIOD,
            fppid_pkg::CFG_REVERSE: begin
                w_gain_start = i_cfg_wr_en;
            end
            fppid_pkg::CFG_OUT_MIN, fppid_pkg::CFG_OUT_MAX: begin
                w_lim_wr = i_cfg_wr_en;
            end
            default: begin
                w_gain_start = 1'b0;
            end
        endcase
    end

    // A limit write takes effect only when it leaves a valid pair.
    assign w_new_min = (w_lim_wr && (i_cfg_idx == fppid_pkg::CFG_OUT_MIN)) ?
                       $signed(i_cfg_wdata) : r_out_min;
    assign w_new_max = (w_lim_wr && (i_cfg_idx == fppid_pkg::CFG_OUT_MAX)) ?
                       $signed(i_cfg_wdata) : r_out_max;
    assign w_lim_ok  = w_lim_wr && (w_new_min < w_new_max);

    // Clamp of held output and accumulator to newly activated limits.
    assign w_acc_clamped = fppid_pkg::f_clamp(fppid_pkg::CALC_W'($signed(r_st.acc)),
                                              fppid_pkg::f_scale(w_new_min),
                                              fppid_pkg::f_scale(w_new_max));
    assign w_held_clamped = ($signed(r_st.held) > w_new_max) ? w_new_max :
                            ($signed(r_st.held) < w_new_min) ? w_new_min :
                            $signed(r_st.held);

    // Effective gain derivation.
    fppid_gains u_gains (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_gain_start),
        .i_gain_p  (r_gain_p),
        .i_gain_i  (r_gain_i),
        .i_gain_d  (r_gain_d),
        .i_raw     (r_raw),
        .i_period  (r_period),
        .i_reverse (r_reverse),
        .o_status  (w_gstat)
    );

    // Unpack the registered input word.
    always_comb begin
        w_item.cmd        = fppid_pkg::t_cmd'(r_in_user);
        w_item.now        = r_in_data[31:0];
        w_item.meas       = r_in_data[47:32];
        w_item.sp         = r_in_data[63:48];
        w_item.ff         = $signed(r_in_data[79:64]);
        w_item.p_on_error = r_in_data[80];
        w_item.manual     = $signed(r_in_data[96:81]);
    end

    fppid_core u_core (
        .i_item     (w_item),
        .i_state    (r_st),
        .i_gains    (w_gstat.gains),
        .i_lim      (r_lim),
        .i_period   (r_period),
        .o_next     (w_next),
        .o_computed (w_computed)
    );

    // Handshakes: the input register moves on whenever the result register is free and no gains are being derived.
    assign w_adv      = r_in_valid && !w_gstat.busy && (!r_out_valid || i_m_tready);
    assign o_s_tready = !w_gstat.busy && !w_gain_start && (!r_in_valid || w_adv);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Control state, configuration registers and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_raw       <= 1'b0;
            r_period    <= fppid_pkg::PER_W'(250);
            r_out_min   <= '0;
            r_out_max   <= fppid_pkg::DATA_W'(255);
            r_reverse   <= 1'b0;
            r_lim.lo    <= '0;
            r_lim.hi    <= fppid_pkg::DATA_W'(255);
            r_st        <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (fppid_pkg::t_cfg_idx'(i_cfg_idx))
                    fppid_pkg::CFG_GAIN_P:    r_gain_p  <= $signed(i_cfg_wdata);
                    fppid_pkg::CFG_GAIN_I:    r_gain_i  <= $signed(i_cfg_wdata);
                    fppid_pkg::CFG_GAIN_D:    r_gain_d  <= $signed(i_cfg_wdata);
                    fppid_pkg::CFG_RAW_GAINS: r_raw     <= i_cfg_wdata[0];
                    fppid_pkg::CFG_PERIOD:    r_period  <= i_cfg_wdata[fppid_pkg::PER_W-1:0];
                    fppid_pkg::CFG_OUT_MIN:   r_out_min <= $signed(i_cfg_wdata);
                    fppid_pkg::CFG_OUT_MAX:   r_out_max <= $signed(i_cfg_wdata);
                    fppid_pkg::CFG_REVERSE:   r_reverse <= i_cfg_wdata[0];
                    default:                  r_reverse <= r_reverse;
                endcase
            end
            if (w_lim_ok) begin
                r_lim.lo <= w_new_min;
                r_lim.hi <= w_new_max;
            end
            if (w_adv) begin
                r_st <= w_next;
            end else if (w_lim_ok && r_st.auto_on) begin
                r_st.held <= w_held_clamped;
                r_st.acc  <= w_acc_clamped[fppid_pkg::ACC_W-1:0];
            end
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_data <= i_s_tdata;
            r_in_user <= i_s_tuser;
        end
        if (w_adv) begin
            r_out_data <= w_next.held;
            r_out_user <= {w_next.auto_on, w_computed};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    // A computed result is only produced in automatic mode.
    a_computed_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> o_m_tuser[1])
        else $error("computed result reported outside automatic mode");

    // A waiting word moves into a free result register in the next cycle when no gains are being derived.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid && !w_gstat.busy) |=> r_out_valid)
        else $error("input word did not advance into free result register");

    // A gain register write holds the input while the gains are derived.
    a_gain_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_gain_start |=> (w_gstat.busy && !o_s_tready))
        else $error("input accepted while effective gains were being derived");

endmodule

`default_nettype wire

// File: hw/rtl/fppid_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module fppid_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [fppid_pkg::DIV_NUM_W-1:0]     i_num,
    input  wire logic [fppid_pkg::DIV_DEN_W-1:0]     i_den,
    output logic                                     o_done,
    output logic [fppid_pkg::DIV_NUM_W-1:0]          o_quo
);

    logic                                r_busy;
    logic                                r_done;
    logic [fppid_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [fppid_pkg::DIV_DEN_W-1:0]     r_rem;
    logic [fppid_pkg::DIV_NUM_W-1:0]     r_quo;
    logic [fppid_pkg::DIV_DEN_W-1:0]     r_den;

    logic [fppid_pkg::DIV_DEN_W:0]       w_trial;
    logic [fppid_pkg::DIV_DEN_W:0]       w_diff;
    logic                                w_fit;
    logic [fppid_pkg::DIV_DEN_W-1:0]     n_rem;

    // Shift in the next dividend bit and try to subtract the divisor.
    assign w_trial = {r_rem, r_quo[fppid_pkg::DIV_NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fit   = (w_trial >= {1'b0, r_den});
    assign n_rem   = w_fit ? w_diff[fppid_pkg::DIV_DEN_W-1:0]
                           : w_trial[fppid_pkg::DIV_DEN_W-1:0];

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= fppid_pkg::DIV_CNT_W'(fppid_pkg::DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == fppid_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[fppid_pkg::DIV_NUM_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// File: hw/rtl/fppid_gains.sv
// Sequencer that derives the effective gains from the tuning registers.
`default_nettype none

module fppid_gains (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [fppid_pkg::DATA_W-1:0] i_gain_p,
    input  wire logic signed [fppid_pkg::DATA_W-1:0] i_gain_i,
    input  wire logic signed [fppid_pkg::DATA_W-1:0] i_gain_d,
    input  wire logic                               i_raw,
    input  wire logic [fppid_pkg::PER_W-1:0]        i_period,
    input  wire logic                               i_reverse,
    output fppid_pkg::t_gain_status                 o_status
);

    typedef enum logic [2:0] {
        G_IDLE,
        G_LOAD,
        G_INV,
        G_KI_START,
        G_KI
    } t_gstate;

    t_gstate                              r_state;
    logic [fppid_pkg::INV_W-1:0]          r_inv;
    fppid_pkg::t_gains                    r_gains;

    logic                                 w_div_start;
    logic [fppid_pkg::DIV_NUM_W-1:0]      w_div_num;
    logic [fppid_pkg::DIV_DEN_W-1:0]      w_div_den;
    logic                                 w_div_done;
    logic [fppid_pkg::DIV_NUM_W-1:0]      w_div_quo;

    logic [fppid_pkg::PER_W-1:0]          w_per;
    logic signed [fppid_pkg::DIV_NUM_W-1:0] w_gi32;
    logic [fppid_pkg::DIV_NUM_W-1:0]      w_gi_mag;
    logic signed [fppid_pkg::KP_W-1:0]    w_kp_scaled;
    logic signed [fppid_pkg::KI_W-1:0]    w_ki_pos;
    logic signed [fppid_pkg::KI_W-1:0]    w_ki_scaled;
    logic signed [fppid_pkg::DATA_W+fppid_pkg::INV_W:0] w_kd_prod;
    logic signed [fppid_pkg::KD_W-1:0]    w_kd_scaled;
    logic signed [fppid_pkg::KP_W-1:0]    w_kp_sel;
    logic signed [fppid_pkg::KI_W-1:0]    w_ki_sel;
    logic signed [fppid_pkg::KD_W-1:0]    w_kd_sel;
    fppid_pkg::t_gains                    n_gains;

    // A zero period acts as one; the scaled integral gain divides by 1000 / period.
    assign w_per    = (i_period == '0) ? fppid_pkg::PER_W'(1) : i_period;
    assign w_gi32   = $signed({i_gain_i, {fppid_pkg::GAIN_SHIFT{1'b0}}});
    assign w_gi_mag = w_gi32[fppid_pkg::DIV_NUM_W-1] ? -w_gi32 : w_gi32;

    // Divider operands: first 1000 / period, then the integral gain magnitude.
    assign w_div_start = (r_state == G_LOAD) || (r_state == G_KI_START);
    assign w_div_num   = (r_state == G_LOAD) ?
                         fppid_pkg::DIV_NUM_W'(fppid_pkg::PERIOD_BASE) : w_gi_mag;
    assign w_div_den   = (r_state == G_LOAD) ? w_per : r_inv;

    fppid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // Scaled gains; the integral quotient truncates toward zero.
    assign w_kp_scaled = $signed({i_gain_p, {fppid_pkg::GAIN_SHIFT{1'b0}}});
    assign w_ki_pos    = $signed({1'b0, w_div_quo});
    assign w_ki_scaled = i_gain_i[fppid_pkg::DATA_W-1] ? -w_ki_pos : w_ki_pos;
    assign w_kd_prod   = i_gain_d * $signed({1'b0, r_inv});
    assign w_kd_scaled = fppid_pkg::KD_W'(w_kd_prod) <<< fppid_pkg::GAIN_SHIFT;

    // Raw or scaled, then the direction sign.
    assign w_kp_sel = i_raw ? fppid_pkg::KP_W'(i_gain_p) : w_kp_scaled;
    assign w_ki_sel = i_raw ? fppid_pkg::KI_W'(i_gain_i) : w_ki_scaled;
    assign w_kd_sel = i_raw ? fppid_pkg::KD_W'(i_gain_d) : w_kd_scaled;

    always_comb begin
        n_gains.kp = i_reverse ? -w_kp_sel : w_kp_sel;
        n_gains.ki = i_reverse ? -w_ki_sel : w_ki_sel;
        n_gains.kd = i_reverse ? -w_kd_sel : w_kd_sel;
    end

    // Sequencer state, the reciprocal period and the gain registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_inv   <= fppid_pkg::INV_W'(1);
            r_gains <= '0;
        end else if (i_start) begin
            r_state <= G_LOAD;
        end else begin
            unique case (r_state)
                G_IDLE: begin
                    r_state <= G_IDLE;
                end
                G_LOAD: begin
                    r_state <= G_INV;
                end
                G_INV: begin
                    if (w_div_done) begin
                        r_inv   <= (w_div_quo == '0) ? fppid_pkg::INV_W'(1)
                                                     : w_div_quo[fppid_pkg::INV_W-1:0];
                        r_state <= G_KI_START;
                    end
                end
                G_KI_START: begin
                    r_state <= G_KI;
                end
                G_KI: begin
                    if (w_div_done) begin
                        r_gains <= n_gains;
                        r_state <= G_IDLE;
                    end
                end
                default: begin
                    r_state <= G_IDLE;
                end
            endcase
        end
    end

    assign o_status.busy  = (r_state != G_IDLE);
    assign o_status.gains = r_gains;

endmodule

`default_nettype wire

// File: hw/rtl/fppid_core.sv
// Single-pass controller datapath: next state and output for one item.
`default_nettype none

module fppid_core (
    input  wire fppid_pkg::t_item              i_item,
    input  wire fppid_pkg::t_state             i_state,
    input  wire fppid_pkg::t_gains             i_gains,
    input  wire fppid_pkg::t_limits            i_lim,
    input  wire logic [fppid_pkg::PER_W-1:0]   i_period,
    output fppid_pkg::t_state                  o_next,
    output logic                               o_computed
);

    localparam int KPP_W = fppid_pkg::KP_W + fppid_pkg::ERR_W;
    localparam int KIP_W = fppid_pkg::KI_W + fppid_pkg::ERR_W;
    localparam int KDP_W = fppid_pkg::KD_W + fppid_pkg::ERR_W;

    logic signed [fppid_pkg::ERR_W-1:0]  w_err;
    logic signed [fppid_pkg::ERR_W-1:0]  w_dm;
    logic signed [fppid_pkg::ERR_W-1:0]  w_kp_opd;
    logic signed [KPP_W-1:0]             w_kp_prod;
    logic signed [KIP_W-1:0]             w_ki_prod;
    logic signed [KDP_W-1:0]             w_kd_prod;
    logic signed [fppid_pkg::CALC_W-1:0] w_lo;
    logic signed [fppid_pkg::CALC_W-1:0] w_hi;
    logic signed [fppid_pkg::CALC_W-1:0] w_ff;
    logic signed [fppid_pkg::CALC_W-1:0] w_acc;
    logic signed [fppid_pkg::CALC_W-1:0] w_acc_i;
    logic signed [fppid_pkg::CALC_W-1:0] w_acc_m;
    logic signed [fppid_pkg::CALC_W-1:0] w_acc_new;
    logic signed [fppid_pkg::CALC_W-1:0] w_pterm;
    logic signed [fppid_pkg::CALC_W-1:0] w_o_pi;
    logic signed [fppid_pkg::CALC_W-1:0] w_d_term;
    logic signed [fppid_pkg::CALC_W-1:0] w_o_pid;
    logic signed [fppid_pkg::CALC_W-1:0] w_o_lim;
    logic signed [fppid_pkg::CALC_W-1:0] w_drive;
    logic signed [fppid_pkg::CALC_W-1:0] w_seed;
    logic [fppid_pkg::TIME_W-1:0]        w_elapsed;
    logic                                w_ki_nz;
    logic                                w_kd_nz;
    logic                                w_due;

    // Error and measurement change.
    assign w_err = $signed({1'b0, i_item.sp}) - $signed({1'b0, i_item.meas});
    assign w_dm  = $signed({1'b0, i_item.meas}) - $signed({1'b0, i_state.prev});

    // Three products: proportional, integral and derivative.
    assign w_kp_opd  = i_item.p_on_error ? w_err : w_dm;
    assign w_kp_prod = $signed(i_gains.kp) * w_kp_opd;
    assign w_ki_prod = $signed(i_gains.ki) * w_err;
    assign w_kd_prod = $signed(i_gains.kd) * w_dm;

    assign w_ki_nz = (i_gains.ki != '0);
    assign w_kd_nz = (i_gains.kd != '0);

    // Limits and feedforward in fixed point.
    assign w_lo  = fppid_pkg::f_scale($signed(i_lim.lo));
    assign w_hi  = fppid_pkg::f_scale($signed(i_lim.hi));
    assign w_ff  = fppid_pkg::f_scale($signed(i_item.ff));
    assign w_acc = fppid_pkg::CALC_W'($signed(i_state.acc));

    // Integral accumulation, clamped to the limits less the feedforward.
    assign w_acc_i = w_ki_nz ?
                     fppid_pkg::f_clamp(w_acc + fppid_pkg::CALC_W'(w_ki_prod),
                                        w_lo - w_ff, w_hi - w_ff) : w_acc;

    // Proportional on measurement folds into the accumulator.
    assign w_acc_m = fppid_pkg::f_clamp(w_acc_i - fppid_pkg::CALC_W'(w_kp_prod),
                                        w_lo, w_hi);

    // Proportional on error adds the product to the accumulator when the integral gain is nonzero.
    assign w_pterm   = fppid_pkg::CALC_W'(w_kp_prod) +
                       (w_ki_nz ? w_acc_i : fppid_pkg::CALC_W'(0));
    assign w_acc_new = i_item.p_on_error ? w_acc_i : w_acc_m;
    assign w_o_pi    = i_item.p_on_error ? w_pterm : w_acc_m;

    // Derivative on measurement, floor-divided by 4.
    assign w_d_term = fppid_pkg::CALC_W'(w_kd_prod) >>> fppid_pkg::D_SHIFT;
    assign w_o_pid  = w_kd_nz ? (w_o_pi - w_d_term) : w_o_pi;

    // Feedforward, saturation and return to output units.
    assign w_o_lim = fppid_pkg::f_clamp(w_o_pid + w_ff, w_lo, w_hi);
    assign w_drive = w_o_lim >>> fppid_pkg::FRAC_BITS;

    // Accumulator seed for a mode change.
    assign w_seed = fppid_pkg::f_clamp(fppid_pkg::f_scale($signed(i_item.manual)),
                                       w_lo, w_hi);

    // Sample period check, modulo 2^32.
    assign w_elapsed = i_item.now - i_state.last;
    assign w_due     = (w_elapsed >= fppid_pkg::TIME_W'(i_period));

    // Command decode and state update.
    always_comb begin
        o_next     = i_state;
        o_computed = 1'b0;
        unique case (i_item.cmd)
            fppid_pkg::CMD_AUTO: begin
                if (!i_state.auto_on) begin
                    o_next.acc  = w_seed[fppid_pkg::ACC_W-1:0];
                    o_next.prev = i_item.meas;
                end
                o_next.auto_on = 1'b1;
            end
            fppid_pkg::CMD_MANUAL: begin
                if (i_state.auto_on) begin
                    o_next.acc  = w_seed[fppid_pkg::ACC_W-1:0];
                    o_next.prev = i_item.meas;
                end
                o_next.auto_on = 1'b0;
            end
            fppid_pkg::CMD_CLEAR: begin
                o_next.acc = '0;
            end
            fppid_pkg::CMD_TICK: begin
                if (i_state.auto_on && w_due && (i_item.meas != '0)) begin
                    o_next.acc  = w_acc_new[fppid_pkg::ACC_W-1:0];
                    o_next.held = w_drive[fppid_pkg::DATA_W-1:0];
                    o_next.prev = i_item.meas;
                    o_next.last = i_item.now;
                    o_computed  = 1'b1;
                end
            end
            default: begin
                o_computed = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_fixed_point_pid_feedforward.sv
// Self-checking testbench for the fixed-point PID controller with feedforward.
`timescale 1ns / 1ps

module tb_fixed_point_pid_feedforward;

    localparam longint ONE_FX = longint'(1) <<< fppid_pkg::FRAC_BITS;
    localparam int     PHASES = 8;
    localparam int     RANDOM_PER_PHASE = 208;

    // One output word as the controller should present it.
    typedef struct {
        logic signed [fppid_pkg::DATA_W-1:0] drive;
        logic                                computed;
        logic                                auto_on;
    } t_drive_word;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_wr_en = 1'b0;
    logic [fppid_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [fppid_pkg::DATA_W-1:0]     i_cfg_wdata = '0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    logic [fppid_pkg::S_TDATA_W-1:0]  i_s_tdata = '0;
    logic [fppid_pkg::CMD_W-1:0]      i_s_tuser = '0;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    logic [fppid_pkg::M_TDATA_W-1:0]  o_m_tdata;
    logic [fppid_pkg::M_TUSER_W-1:0]  o_m_tuser;

    // Register copies as last written.
    longint kp_set, ki_set, kd_set, lim_min_reg, lim_max_reg;
    logic   raw_mode, reverse_on;
    int     period_ms;

    // Controller state as the block should hold it.
    longint                        pid_acc, drive_held, act_lo, act_hi;
    logic [fppid_pkg::DATA_W-1:0]  last_meas;
    logic [fppid_pkg::TIME_W-1:0]  last_tick_ms;
    logic                          auto_on;

    // Stimulus and scoreboard.
    fppid_pkg::t_item  pending_q[$];
    t_drive_word       drive_expect_q[$];
    fppid_pkg::t_item  send_item;
    t_drive_word       drive_want;
    logic [fppid_pkg::TIME_W-1:0] sim_ms;
    int base_sp;
    int burst_left = 0, gap_left = 0;
    int stall_left = 0, hold_requests = 0, hold_served = 0;
    bit sender_steady = 1'b0, sink_steady = 1'b0;
    int n_errors = 0, n_accepted = 0, n_results = 0, n_computed = 0;
    int n_cfg_writes = 0, n_long_holds = 0;

    fixed_point_pid_feedforward dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // A mode change loads the accumulator from the manual output for a bumpless switch.
    function automatic void load_bumpless(input logic signed [fppid_pkg::DATA_W-1:0] manual,
                                          input logic [fppid_pkg::DATA_W-1:0] meas);
        pid_acc   = sat(longint'(manual) * ONE_FX, act_lo * ONE_FX, act_hi * ONE_FX);
        last_meas = meas;
    endfunction

    // Advance the controller by one input word and return the word it should emit.
    function automatic t_drive_word pid_step(input fppid_pkg::t_item it);
        t_drive_word                  r;
        longint                       kp, ki, kd, inv, err, dm, ffs, lo, hi, o;
        logic [fppid_pkg::TIME_W-1:0] elapsed;
        r.computed = 1'b0;
        elapsed = it.now - last_tick_ms;
        case (it.cmd)
            fppid_pkg::CMD_AUTO: begin
                if (!auto_on) load_bumpless(it.manual, it.meas);
                auto_on = 1'b1;
            end
            fppid_pkg::CMD_MANUAL: begin
                if (auto_on) load_bumpless(it.manual, it.meas);
                auto_on = 1'b0;
            end
            fppid_pkg::CMD_CLEAR: begin
                pid_acc = 0;
            end
            default: begin
                if (auto_on && elapsed >= period_ms && it.meas != '0) begin
                    // Effective gains follow from the registers alone.
                    if (raw_mode) begin
                        kp = kp_set;
                        ki = ki_set;
                        kd = kd_set;
                    end else begin
                        inv = 1000 / ((period_ms == 0) ? 1 : period_ms);
                        if (inv == 0) inv = 1;
                        kp = kp_set * 32;
                        ki = (ki_set * 32) / inv;
                        kd = kd_set * 32 * inv;
                    end
                    if (reverse_on) begin
                        kp = -kp;
                        ki = -ki;
                        kd = -kd;
                    end
                    err = longint'(it.sp) - longint'(it.meas);
                    dm  = longint'(it.meas) - longint'(last_meas);
                    ffs = longint'($signed(it.ff)) * ONE_FX;
                    lo  = act_lo * ONE_FX;
                    hi  = act_hi * ONE_FX;
                    // The integral window is shifted by the feedforward contribution.
                    if (ki != 0) pid_acc = sat(pid_acc + ki * err, lo - ffs, hi - ffs);
                    if (it.p_on_error) begin
                        o = kp * err;
                        if (ki != 0) o += pid_acc;
                    end else begin
                        pid_acc = sat(pid_acc - kp * dm, lo, hi);
                        o = pid_acc;
                    end
                    if (kd != 0) o -= (kd * dm) >>> 2;
                    o = sat(o + ffs, lo, hi);
                    drive_held   = o >>> fppid_pkg::FRAC_BITS;
                    last_meas    = it.meas;
                    last_tick_ms = it.now;
                    r.computed   = 1'b1;
                end
            end
        endcase
        r.drive   = drive_held[fppid_pkg::DATA_W-1:0];
        r.auto_on = auto_on;
        return r;
    endfunction

    function automatic fppid_pkg::t_item mk_item(input fppid_pkg::t_cmd c,
                                                 input logic [fppid_pkg::TIME_W-1:0] now,
                                                 input logic [fppid_pkg::DATA_W-1:0] meas,
                                                 input logic [fppid_pkg::DATA_W-1:0] sp,
                                                 input int ff, input logic pone,
                                                 input int manual);
        fppid_pkg::t_item it;
        it.cmd        = c;
        it.now        = now;
        it.meas       = meas;
        it.sp         = sp;
        it.ff         = fppid_pkg::DATA_W'(ff);
        it.p_on_error = pone;
        it.manual     = fppid_pkg::DATA_W'(manual);
        return it;
    endfunction

    // Mostly well-paced ticks around a drifting setpoint, with mode commands and noise.
    function automatic fppid_pkg::t_item rand_item();
        fppid_pkg::t_item it;
        int               roll, per, noise, m;
        per  = (period_ms == 0) ? 1 : period_ms;
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            it.cmd = fppid_pkg::CMD_AUTO;
        end else if (roll < 6) begin
            it.cmd = fppid_pkg::CMD_MANUAL;
        end else if (roll < 9) begin
            it.cmd = fppid_pkg::CMD_CLEAR;
        end else begin
            it.cmd = fppid_pkg::CMD_TICK;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            sim_ms = $urandom();
        end else if (roll < 15) begin
            sim_ms += $urandom_range(0, per - 1);
        end else begin
            sim_ms += $urandom_range(per, per + per / 2 + 1);
        end
        it.now = sim_ms;
        if ($urandom_range(0, 99) < 4) base_sp = $urandom_range(0, 65535);
        it.sp = ($urandom_range(0, 99) < 10) ? fppid_pkg::DATA_W'($urandom())
                                             : fppid_pkg::DATA_W'(base_sp);
        noise = int'($urandom_range(0, 400)) - 200;
        m = base_sp + noise;
        if (m < 1) m = 1;
        if (m > 65535) m = 65535;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            it.meas = '0;
        end else if (roll < 12) begin
            it.meas = fppid_pkg::DATA_W'($urandom());
        end else begin
            it.meas = fppid_pkg::DATA_W'(m);
        end
        if ($urandom_range(0, 99) < 10) begin
            it.ff = fppid_pkg::DATA_W'($urandom());
        end else begin
            it.ff = fppid_pkg::DATA_W'(int'($urandom_range(0, 100)) - 50);
        end
        it.p_on_error = 1'($urandom_range(0, 1));
        it.manual     = fppid_pkg::DATA_W'($urandom());
        return it;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH word %0d: %s got %0d expected %0d", n_results, what, got, want);
        n_errors++;
    endtask

    // Write one register at the current edge and track its effect on the predictor.
    task automatic cfg_write(input fppid_pkg::t_cfg_idx idx, input int val);
        logic [fppid_pkg::DATA_W-1:0] wval;
        wval = fppid_pkg::DATA_W'(val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= wval;
        n_cfg_writes++;
        case (idx) inside
            fppid_pkg::CFG_GAIN_P:    kp_set = longint'($signed(wval));
            fppid_pkg::CFG_GAIN_I:    ki_set = longint'($signed(wval));
            fppid_pkg::CFG_GAIN_D:    kd_set = longint'($signed(wval));
            fppid_pkg::CFG_RAW_GAINS: raw_mode = wval[0];
            fppid_pkg::CFG_PERIOD:    period_ms = int'(wval[fppid_pkg::PER_W-1:0]);
            fppid_pkg::CFG_OUT_MIN, fppid_pkg::CFG_OUT_MAX: begin
                if (idx == fppid_pkg::CFG_OUT_MIN) begin
                    lim_min_reg = longint'($signed(wval));
                end else begin
                    lim_max_reg = longint'($signed(wval));
                end
                // Only a valid pair becomes active; in automatic mode it pulls state inside.
                if (lim_min_reg < lim_max_reg) begin
                    act_lo = lim_min_reg;
                    act_hi = lim_max_reg;
                    if (auto_on) begin
                        drive_held = sat(drive_held, act_lo, act_hi);
                        pid_acc    = sat(pid_acc, act_lo * ONE_FX, act_hi * ONE_FX);
                    end
                end
            end
            fppid_pkg::CFG_REVERSE:   reverse_on = wval[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Wait until every queued word has gone through and every result has come back.
    task automatic settle();
        int guard;
        guard = 0;
        while ((pending_q.size() != 0 || i_s_tvalid || drive_expect_q.size() != 0)
               && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    // Input driver: bursts of words with random gaps in between.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                drive_expect_q.push_back(pid_step(send_item));
                n_accepted++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0 && !sender_steady) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    send_item = pending_q.pop_front();
                    i_s_tdata <= fppid_pkg::S_TDATA_W'({send_item.manual,
                                                        send_item.p_on_error,
                                                        send_item.ff, send_item.sp,
                                                        send_item.meas, send_item.now});
                    i_s_tuser  <= send_item.cmd;
                    i_s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = $urandom_range(1, 6);
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: short random stalls, plus long hold-offs on request.
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served++;
            stall_left = 300;
            n_long_holds++;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (!sink_steady && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Output monitor: compare each word with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (drive_expect_q.size() == 0) begin
                flag_mismatch("word with nothing pending, drive",
                              longint'($signed(o_m_tdata)), 0);
            end else begin
                drive_want = drive_expect_q.pop_front();
                if (o_m_tdata !== drive_want.drive)
                    flag_mismatch("drive_output", longint'($signed(o_m_tdata)),
                                  longint'(drive_want.drive));
                if (o_m_tuser[0] !== drive_want.computed)
                    flag_mismatch("computed", longint'(o_m_tuser[0]),
                                  longint'(drive_want.computed));
                if (o_m_tuser[1] !== drive_want.auto_on)
                    flag_mismatch("auto_active", longint'(o_m_tuser[1]),
                                  longint'(drive_want.auto_on));
                if (drive_want.computed) n_computed++;
            end
            n_results++;
        end
    end

    // Stimulus: reset, directed words, then one random phase per register setting.
    initial begin
        kp_set = 0; ki_set = 0; kd_set = 0;
        raw_mode = 1'b0; period_ms = 250; reverse_on = 1'b0;
        lim_min_reg = 0; lim_max_reg = 255;
        pid_acc = 0; drive_held = 0; act_lo = 0; act_hi = 255;
        last_meas = '0; last_tick_ms = '0; auto_on = 1'b0;
        sim_ms = 1000;
        base_sp = 1000;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: tick in manual, clear, seed above the default limit, first tick.
        pending_q.push_back(mk_item(fppid_pkg::CMD_TICK, 32'd0, 16'd700, 16'd800, 0, 1'b1,
                                    0));
        pending_q.push_back(mk_item(fppid_pkg::CMD_CLEAR, 32'd0, 16'd700, 16'd800, 0, 1'b0,
                                    0));
        pending_q.push_back(mk_item(fppid_pkg::CMD_AUTO, 32'd10, 16'd700, 16'd800, 0, 1'b0,
                                    300));
        pending_q.push_back(mk_item(fppid_pkg::CMD_TICK, 32'd250, 16'd700, 16'd800, 3, 1'b0,
                                    0));

        for (int p = 0; p < PHASES; p++) begin
            settle();
            sender_steady = (p == 2 || p == 5);
            sink_steady   = (p == 3 || p == 5);
            case (p)
                0: begin
                    cfg_write(fppid_pkg::CFG_GAIN_P, 40);
                    cfg_write(fppid_pkg::CFG_GAIN_I, 8);
                    cfg_write(fppid_pkg::CFG_GAIN_D, 3);
                    cfg_write(fppid_pkg::CFG_RAW_GAINS, 0);
                    cfg_write(fppid_pkg::CFG_PERIOD, 10);
                    cfg_write(fppid_pkg::CFG_OUT_MIN, -2000);
                    cfg_write(fppid_pkg::CFG_OUT_MAX, 2000);
                    cfg_write(fppid_pkg::CFG_REVERSE, 0);
                end
                1: begin
                    cfg_write(fppid_pkg::CFG_GAIN_P, -32768);
                    cfg_write(fppid_pkg::CFG_GAIN_I, 32767);
                    cfg_write(fppid_pkg::CFG_GAIN_D, -32768);
                    cfg_write(fppid_pkg::CFG_RAW_GAINS, 1);
                    cfg_write(fppid_pkg::CFG_PERIOD, 1);
                    cfg_write(fppid_pkg::CFG_OUT_MIN, -32768);
                    cfg_write(fppid_pkg::CFG_OUT_MAX, 32767);
                end
                2: begin
                    cfg_write(fppid_pkg::CFG_GAIN_P, 32767);
                    cfg_write(fppid_pkg::CFG_GAIN_I, -32768);
                    cfg_write(fppid_pkg::CFG_GAIN_D, 32767);
                    cfg_write(fppid_pkg::CFG_RAW_GAINS, 0);
                    cfg_write(fppid_pkg::CFG_PERIOD, 1000);
                    cfg_write(fppid_pkg::CFG_REVERSE, 1);
                end
                3: begin
                    // Period zero: every tick is due.
                    cfg_write(fppid_pkg::CFG_GAIN_P, 300);
                    cfg_write(fppid_pkg::CFG_GAIN_I, 50);
                    cfg_write(fppid_pkg::CFG_GAIN_D, 20);
                    cfg_write(fppid_pkg::CFG_RAW_GAINS, 1);
                    cfg_write(fppid_pkg::CFG_PERIOD, 0);
                    cfg_write(fppid_pkg::CFG_OUT_MIN, 0);
                    cfg_write(fppid_pkg::CFG_OUT_MAX, 255);
                end
                4: begin
                    // No integral or derivative term; period above one second.
                    cfg_write(fppid_pkg::CFG_GAIN_P, 100);
                    cfg_write(fppid_pkg::CFG_GAIN_I, 0);
                    cfg_write(fppid_pkg::CFG_GAIN_D, 0);
                    cfg_write(fppid_pkg::CFG_RAW_GAINS, 0);
                    cfg_write(fppid_pkg::CFG_PERIOD, 1023);
                    cfg_write(fppid_pkg::CFG_OUT_MIN, -500);
                    cfg_write(fppid_pkg::CFG_OUT_MAX, 500);
                    cfg_write(fppid_pkg::CFG_REVERSE, 0);
                end
                5: begin
                    // Narrow the upper limit, then leave an inverted pair stored.
                    cfg_write(fppid_pkg::CFG_GAIN_P, 12);
                    cfg_write(fppid_pkg::CFG_GAIN_I, 3);
                    cfg_write(fppid_pkg::CFG_GAIN_D, 1);
                    cfg_write(fppid_pkg::CFG_PERIOD, 7);
                    cfg_write(fppid_pkg::CFG_REVERSE, 1);
                    cfg_write(fppid_pkg::CFG_OUT_MAX, 100);
                    cfg_write(fppid_pkg::CFG_OUT_MIN, 200);
                end
                6: begin
                    // Equal limits are refused before a valid upper limit arrives.
                    cfg_write(fppid_pkg::CFG_GAIN_P, int'($urandom_range(0, 4000)) - 2000);
                    cfg_write(fppid_pkg::CFG_GAIN_I, int'($urandom_range(0, 4000)) - 2000);
                    cfg_write(fppid_pkg::CFG_GAIN_D, int'($urandom_range(0, 4000)) - 2000);
                    cfg_write(fppid_pkg::CFG_RAW_GAINS, $urandom_range(0, 1));
                    cfg_write(fppid_pkg::CFG_PERIOD, $urandom_range(1, 40));
                    cfg_write(fppid_pkg::CFG_OUT_MIN, -300);
                    cfg_write(fppid_pkg::CFG_OUT_MAX, -300);
                    cfg_write(fppid_pkg::CFG_OUT_MAX, $urandom_range(1, 3000));
                end
                default: begin
                    cfg_write(fppid_pkg::CFG_GAIN_P, $urandom());
                    cfg_write(fppid_pkg::CFG_GAIN_I, $urandom());
                    cfg_write(fppid_pkg::CFG_GAIN_D, $urandom());
                    cfg_write(fppid_pkg::CFG_RAW_GAINS, $urandom_range(0, 1));
                    cfg_write(fppid_pkg::CFG_PERIOD, $urandom_range(0, 1023));
                    cfg_write(fppid_pkg::CFG_OUT_MIN, -int'($urandom_range(0, 32768)));
                    cfg_write(fppid_pkg::CFG_OUT_MAX, $urandom_range(1, 32767));
                    cfg_write(fppid_pkg::CFG_REVERSE, $urandom_range(0, 1));
                end
            endcase
            i_cfg_wr_en <= 1'b0;

            if (p == 0) begin
                // Early and zero-measurement ticks, field extremes, repeated modes,
                // clears in automatic mode and a time wrap past 2^32.
                pending_q.push_back(mk_item(fppid_pkg::CMD_TICK, 32'd260, 16'd1000,
                                            16'd1200, 0, 1'b1, 7));
                pending_q.push_back(mk_item(fppid_pkg::CMD_TICK, 32'd265, 16'd1010,
                                            16'd1200, 0, 1'b1, 7));
                pending_q.push_back(mk_item(fppid_pkg::CMD_TICK, 32'd280, 16'd0,
                                            16'd1200, 0, 1'b1, 7));
                pending_q.push_back(mk_item(fppid_pkg::CMD_TICK, 32'd290, 16'hFFFF,
                                            16'd0, -32768, 1'b0, -1));
                pending_q.push_back(mk_item(fppid_pkg::CMD_TICK, 32'd300, 16'd1,
                                            16'hFFFF, 32767, 1'b1, 0));
                pending_q.push_back(mk_item(fppid_pkg::CMD_AUTO, 32'd301, 16'd900,
                                            16'd900, 0, 1'b0, -32768));
                pending_q.push_back(mk_item(fppid_pkg::CMD_CLEAR, 32'd302, 16'd900,
                                            16'd900, 0, 1'b0, 0));
                pending_q.push_back(mk_item(fppid_pkg::CMD_TICK, 32'd310, 16'd500,
                                            16'd500, 10, 1'b0, 0));
                pending_q.push_back(mk_item(fppid_pkg::CMD_MANUAL, 32'd320, 16'd123,
                                            16'd500, 0, 1'b0, 32767));
                pending_q.push_back(mk_item(fppid_pkg::CMD_TICK, 32'd400, 16'd600,
                                            16'd500, 0, 1'b1, 0));
                pending_q.push_back(mk_item(fppid_pkg::CMD_MANUAL, 32'd401, 16'd600,
                                            16'd500, 0, 1'b0, -5));
                pending_q.push_back(mk_item(fppid_pkg::CMD_AUTO, 32'd402, 16'd700,
                                            16'd500, 0, 1'b0, -32768));
                pending_q.push_back(mk_item(fppid_pkg::CMD_TICK, 32'hFFFF_FFFF, 16'd800,
                                            16'd900, -5, 1'b1, 0));
                pending_q.push_back(mk_item(fppid_pkg::CMD_TICK, 32'd5, 16'd810,
                                            16'd900, -5, 1'b1, 0));
                pending_q.push_back(mk_item(fppid_pkg::CMD_TICK, 32'd9, 16'd820,
                                            16'd900, -5, 1'b0, 0));
                pending_q.push_back(mk_item(fppid_pkg::CMD_CLEAR, 32'd10, 16'd820,
                                            16'd900, 0, 1'b1, 0));
                pending_q.push_back(mk_item(fppid_pkg::CMD_TICK, 32'd30, 16'h8000,
                                            16'h7FFF, -1, 1'b0, 0));
                pending_q.push_back(mk_item(fppid_pkg::CMD_TICK, 32'd40, 16'd1000,
                                            16'd1000, 0, 1'b1, 0));
                sim_ms = 40;
            end

            // Hold the output off for a long stretch so the input backs up.
            if (p == 1 || p == 4) hold_requests++;
            for (int k = 0; k < RANDOM_PER_PHASE; k++) pending_q.push_back(rand_item());
            // End in automatic mode so the next limit writes pull state inside.
            pending_q.push_back(mk_item(fppid_pkg::CMD_AUTO, sim_ms,
                                        fppid_pkg::DATA_W'(base_sp),
                                        fppid_pkg::DATA_W'(base_sp),
                                        0, 1'b0, $urandom()));
        end

        settle();
        if (pending_q.size() != 0 || i_s_tvalid)
            flag_mismatch("words never accepted, pending", longint'(pending_q.size()), 0);
        while (drive_expect_q.size() != 0) begin
            drive_want = drive_expect_q.pop_front();
            flag_mismatch("word never arrived, drive", 0, longint'(drive_want.drive));
        end
        $display("Summary: %0d words in, %0d checked, %0d with a fresh control output.",
                 n_accepted, n_results, n_computed);
        $display("Register writes: %0d over %0d settings; long output hold-offs: %0d.",
                 n_cfg_writes, PHASES, n_long_holds);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
